### rtl/core/texture_column_rasterizer_assert.svh
// assertion macros for the texture column rasteriser
`ifndef TEXTURE_COLUMN_RASTERIZER_ASSERT_SVH
`define TEXTURE_COLUMN_RASTERIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCR_ASSERT_SAME(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tcr same-cycle check failed");

// next-cycle implication, checked outside reset
`define TCR_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tcr next-cycle check failed");

`endif

### rtl/core/tcr_pkg.sv
// shared types and constants for the texture column rasteriser
package tcr_pkg;

  localparam int COORD_BITS     = 12;
  localparam int FRAC_BITS      = 16;
  localparam int ACC_BITS       = 40;
  localparam int ALPHA_SHIFT    = 24;
  localparam int DIM_BITS       = 13;
  localparam int ROW_BITS       = 21;
  localparam int STEP_BITS      = 32;
  localparam int TEXEL_BITS     = 32;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = DIM_BITS;
  localparam int IN_TDATA_BITS  = 136;
  localparam int OUT_TDATA_BITS = 80;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TEXTURE_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET  = 13'd480;
  localparam logic [DIM_BITS-1:0] TEXTURE_HEIGHT_RESET = 13'd64;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_TEXEL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic signed [ROW_BITS-1:0]  start_row;
    logic signed [ROW_BITS-1:0]  end_row;
    logic [STEP_BITS-1:0]        step;
    logic [COORD_BITS-1:0]       texture_column;
    logic [COORD_BITS-1:0]       screen_column;
    logic [TEXEL_BITS-1:0]       texel;
  } in_item_t;

  typedef struct packed {
    logic                  fetch_valid;
    logic [COORD_BITS-1:0] fetch_row;
    logic [COORD_BITS-1:0] fetch_col;
    logic                  write_en;
    logic [COORD_BITS-1:0] write_row;
    logic [COORD_BITS-1:0] write_col;
    logic [TEXEL_BITS-1:0] color;
    logic                  column_done;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic load;
    logic busy;
  } core_status_t;

endpackage

### rtl/core/tcr_in_reg.sv
// input register stage for incoming beats
module tcr_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  input  tcr_pkg::in_item_t s_item,
  output logic             s_ready,
  input  logic             take,
  output logic             valid,
  output tcr_pkg::in_item_t item
);

  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

### rtl/core/tcr_core.sv
// column state, clipping, texel stepping and result formation
module tcr_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tcr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  input  tcr_pkg::in_item_t                   item,
  input  logic                                out_free,
  output tcr_pkg::core_status_t               status,
  output tcr_pkg::out_item_t                  res
);

  localparam int IP_BITS   = tcr_pkg::ACC_BITS - tcr_pkg::FRAC_BITS;
  localparam int PROD_BITS = tcr_pkg::ROW_BITS + tcr_pkg::STEP_BITS;
  localparam int SROW_BITS = tcr_pkg::ROW_BITS + 1;
  localparam logic [tcr_pkg::ACC_BITS-1:0] ACC_MAX = '1;

  logic [tcr_pkg::DIM_BITS-1:0]   screen_height;
  logic [tcr_pkg::DIM_BITS-1:0]   texture_height;
  logic                           busy;
  logic [tcr_pkg::DIM_BITS-1:0]   row_counter;
  logic [tcr_pkg::DIM_BITS-1:0]   row_limit;
  logic [tcr_pkg::ACC_BITS-1:0]   tex_accum;
  logic [tcr_pkg::STEP_BITS-1:0]  step_reg;
  logic [tcr_pkg::COORD_BITS-1:0] tex_col_reg;
  logic [tcr_pkg::COORD_BITS-1:0] scr_col_reg;

  logic                           fire;
  logic                           is_begin;
  logic                           neg;
  logic [tcr_pkg::ROW_BITS-1:0]   clip_rows;
  logic [PROD_BITS-1:0]           product;
  logic [tcr_pkg::ACC_BITS-1:0]   acc_begin;
  logic signed [SROW_BITS-1:0]    row_begin;
  logic signed [SROW_BITS-1:0]    end_ext;
  logic signed [SROW_BITS-1:0]    sh_ext;
  logic signed [SROW_BITS-1:0]    lim;
  logic                           empty;
  logic [tcr_pkg::ACC_BITS:0]     acc_sum;
  logic [tcr_pkg::ACC_BITS-1:0]   acc_step;
  logic [tcr_pkg::DIM_BITS-1:0]   rc_inc;
  logic                           more;
  logic                           busy_next;

  // texel row from accumulator, clamped to the texture and the coordinate range
  function automatic logic [tcr_pkg::COORD_BITS-1:0] clamp_row(
    input logic [tcr_pkg::ACC_BITS-1:0] acc,
    input logic [tcr_pkg::DIM_BITS-1:0] th
  );
    logic [IP_BITS-1:0] ip;
    logic [IP_BITS-1:0] th_w;
    logic [IP_BITS-1:0] r;
    ip   = acc[tcr_pkg::ACC_BITS-1:tcr_pkg::FRAC_BITS];
    th_w = IP_BITS'(th);
    if (th == '0) begin
      r = '0;
    end else if (ip >= th_w) begin
      r = th_w - 1'b1;
    end else begin
      r = ip;
    end
    if (r > IP_BITS'({tcr_pkg::COORD_BITS{1'b1}})) begin
      r = IP_BITS'({tcr_pkg::COORD_BITS{1'b1}});
    end
    return r[tcr_pkg::COORD_BITS-1:0];
  endfunction

  assign is_begin = (item.cmd == tcr_pkg::CMD_BEGIN);
  assign fire     = in_valid && out_free;

  // begin beat: clip rows above the screen and pre-advance the accumulator
  assign neg       = item.start_row[tcr_pkg::ROW_BITS-1];
  assign clip_rows = tcr_pkg::ROW_BITS'(-item.start_row);
  assign product   = {{tcr_pkg::STEP_BITS{1'b0}}, clip_rows}
                   * {{tcr_pkg::ROW_BITS{1'b0}}, item.step};
  assign acc_begin = !neg ? '0 :
                     (|product[PROD_BITS-1:tcr_pkg::ACC_BITS]) ? ACC_MAX :
                     product[tcr_pkg::ACC_BITS-1:0];
  assign row_begin = neg ? '0 : $signed({1'b0, item.start_row});
  assign end_ext   = $signed({item.end_row[tcr_pkg::ROW_BITS-1], item.end_row});
  assign sh_ext    = $signed({{(SROW_BITS - tcr_pkg::DIM_BITS){1'b0}}, screen_height});
  assign lim       = (end_ext < sh_ext) ? end_ext : sh_ext;
  assign empty     = (row_begin >= lim);

  // texel beat: step the accumulator with saturation and move to the next row
  assign acc_sum  = {1'b0, tex_accum}
                  + {{(tcr_pkg::ACC_BITS + 1 - tcr_pkg::STEP_BITS){1'b0}}, step_reg};
  assign acc_step = acc_sum[tcr_pkg::ACC_BITS] ? ACC_MAX : acc_sum[tcr_pkg::ACC_BITS-1:0];
  assign rc_inc   = row_counter + 1'b1;
  assign more     = (rc_inc < row_limit);

  always_comb begin
    res       = '0;
    busy_next = busy;
    if (is_begin) begin
      busy_next = !empty;
      if (empty) begin
        res.column_done = 1'b1;
      end else begin
        res.fetch_valid = 1'b1;
        res.fetch_row   = clamp_row(acc_begin, texture_height);
        res.fetch_col   = item.texture_column;
      end
    end else if (busy) begin
      busy_next     = more;
      res.write_en  = (item.texel[tcr_pkg::TEXEL_BITS-1:tcr_pkg::ALPHA_SHIFT] == '0);
      res.color     = res.write_en ? item.texel : '0;
      res.write_row = row_counter[tcr_pkg::COORD_BITS-1:0];
      res.write_col = scr_col_reg;
      if (more) begin
        res.fetch_valid = 1'b1;
        res.fetch_row   = clamp_row(acc_step, texture_height);
        res.fetch_col   = tex_col_reg;
      end else begin
        res.column_done = 1'b1;
      end
    end
  end

  // a texel beat with no fetch pending is dropped without a result
  assign status.take = fire;
  assign status.load = fire && (is_begin || busy);
  assign status.busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      screen_height  <= tcr_pkg::SCREEN_HEIGHT_RESET;
      texture_height <= tcr_pkg::TEXTURE_HEIGHT_RESET;
    end else begin
      if (fire) begin
        busy <= busy_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tcr_pkg::REG_SCREEN_HEIGHT:  screen_height  <= cfg_data;
          tcr_pkg::REG_TEXTURE_HEIGHT: texture_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (is_begin) begin
        step_reg    <= item.step;
        tex_col_reg <= item.texture_column;
        scr_col_reg <= item.screen_column;
        if (!empty) begin
          row_counter <= row_begin[tcr_pkg::DIM_BITS-1:0];
          row_limit   <= lim[tcr_pkg::DIM_BITS-1:0];
          tex_accum   <= acc_begin;
        end
      end else if (busy) begin
        row_counter <= rc_inc;
        tex_accum   <= acc_step;
      end
    end
  end

endmodule

### rtl/core/tcr_out_reg.sv
// result register in front of the master side
module tcr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tcr_pkg::out_item_t load_item,
  output logic               free,
  input  logic               m_ready,
  output logic               valid,
  output tcr_pkg::out_item_t item
);

  assign free = !valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

endmodule

### rtl/core/texture_column_rasterizer.sv
// texture column rasteriser: begin beats open a column, texel beats yield pixels
// usage:
//   slave side carries commands: tuser 0 opens a column (start/end row, 16.16 step,
//   texel column, screen column), tuser 1 returns the texel for the pending fetch.
//   each accepted beat gives at most one master beat: a fetch request for the next
//   texel row, a pixel write (when the texel alpha byte is zero), and tlast when the
//   column has no more rows. a texel beat with no fetch pending gives nothing.
//   config channel writes screen_height (index 0) and texture_height (index 1);
//   write these only while the block is idle.
// timing:
//   a beat accepted into the input register is processed by the core and loaded
//   into the result register, which drives the master side. one beat per cycle
//   sustained while the master side accepts; the column state update (one 21x32
//   multiply on begin, one 40-bit add on texel) is combinational, so a texel may
//   follow its fetch request directly.
// reset and stalls:
//   rst (synchronous) empties both registers, leaves no column open and restores
//   screen_height 480 and texture_height 64. when the master side stalls, the result
//   holds and the input register fills, after which s_tready drops.
module texture_column_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // start_row[20:0], end_row[41:21], step[73:42], texture_column[85:74],
  // screen_column[97:86], texel[129:98], zero pad above
  input  logic [tcr_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  // cmd
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // fetch_row[11:0], fetch_col[23:12], write_row[35:24], write_col[47:36],
  // color[79:48]
  output logic [tcr_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  // fetch_valid[0], write_en[1]
  output logic [1:0]                          m_tuser,
  // column_done
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tcr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  tcr_pkg::in_item_t     s_item;
  tcr_pkg::in_item_t     in_item;
  logic                  in_valid;
  tcr_pkg::core_status_t status;
  tcr_pkg::out_item_t    load_item;
  tcr_pkg::out_item_t    out_item;
  logic                  out_free;

  assign s_item.cmd            = tcr_pkg::cmd_t'(s_tuser);
  assign s_item.start_row      = $signed(s_tdata[20:0]);
  assign s_item.end_row        = $signed(s_tdata[41:21]);
  assign s_item.step           = s_tdata[73:42];
  assign s_item.texture_column = s_tdata[85:74];
  assign s_item.screen_column  = s_tdata[97:86];
  assign s_item.texel          = s_tdata[129:98];

  assign cfg_ready = 1'b1;

  tcr_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_item  (s_item),
    .s_ready (s_tready),
    .take    (status.take),
    .valid   (in_valid),
    .item    (in_item)
  );

  tcr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .item      (in_item),
    .out_free  (out_free),
    .status    (status),
    .res       (load_item)
  );

  tcr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (status.load),
    .load_item (load_item),
    .free      (out_free),
    .m_ready   (m_tready),
    .valid     (m_tvalid),
    .item      (out_item)
  );

  assign m_tdata = {out_item.color, out_item.write_col, out_item.write_row,
                    out_item.fetch_col, out_item.fetch_row};
  assign m_tuser = {out_item.write_en, out_item.fetch_valid};
  assign m_tlast = out_item.column_done;

`include "texture_column_rasterizer_assert.svh"

  // a finished column leaves no fetch pending
  `TCR_ASSERT_NEXT(a_done_idle, status.load && load_item.column_done, !status.busy)
  // a fetch request always leaves a column open
  `TCR_ASSERT_NEXT(a_fetch_busy, status.load && load_item.fetch_valid, status.busy)
  // a result never both asks for a row and closes the column
  `TCR_ASSERT_SAME(a_fetch_or_done, m_tvalid, !(m_tuser[0] && m_tlast))
  // only opaque texels reach the frame
  `TCR_ASSERT_SAME(a_write_opaque, m_tvalid && m_tuser[1], m_tdata[79:72] == 8'd0)

endmodule
